// File: rtl/core/tft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tft_pkg
// Shared widths, limits and types for the FIFO-replacement translation core.
// ----------------------------------------------------------------------------
package tft_pkg;

    // Field widths of the address word and the result word
    localparam int ADDR_W     = 16;
    localparam int PAGE_W     = 8;
    localparam int OFFSET_W   = 8;
    localparam int FRAME_W    = 7;
    localparam int PHYS_W     = FRAME_W + OFFSET_W;
    localparam int CNT_W      = 16;

    // Page size is fixed by the offset field
    localparam int PAGE_BYTES = 256;

    // Defaults for the top-level parameters
    localparam int DEF_TLB_ENTRIES = 16;
    localparam int DEF_FRAME_COUNT = 128;

    // Saturation limit of the hit and fault counters
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Write request into the entry store (address travels separately)
    typedef struct packed {
        logic               en;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } t_wr_req;

    // Registered read data from the entry store
    typedef struct packed {
        logic               valid;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } t_rd_data;

endpackage

// File: rtl/core/tft_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tft_ifs
// Valid/ready channels: logical address words in, translation words out.
// ----------------------------------------------------------------------------
interface tft_in_if
    import tft_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] logical_address;

    modport source (output valid, output logical_address, input ready);
    modport sink   (input valid, input logical_address, output ready);
endinterface

interface tft_out_if
    import tft_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               tlb_hit;
    logic               status;
    logic [PAGE_W-1:0]  page_number;
    logic [FRAME_W-1:0] frame_number;
    logic [PHYS_W-1:0]  physical_address;
    logic [CNT_W-1:0]   hit_total;
    logic [CNT_W-1:0]   fault_total;

    modport source (
        output valid, output tlb_hit, output status, output page_number,
        output frame_number, output physical_address, output hit_total,
        output fault_total, input ready
    );
    modport sink (
        input valid, input tlb_hit, input status, input page_number,
        input frame_number, input physical_address, input hit_total,
        input fault_total, output ready
    );
endinterface

// File: rtl/core/tft_tlb_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tft_tlb_store
// Entry store: page and frame memory with one write and one registered read
// port, plus a valid flag per entry cleared at reset.
// ----------------------------------------------------------------------------
module tft_tlb_store
    import tft_pkg::*;
#(
    parameter int TLB_ENTRIES = DEF_TLB_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [$clog2(TLB_ENTRIES)-1:0] i_rd_addr,
    input  logic [$clog2(TLB_ENTRIES)-1:0] i_wr_addr,
    input  t_wr_req                        i_wr,
    output t_rd_data                       o_rd
);

    logic [PAGE_W-1:0]      r_mem_page  [TLB_ENTRIES];
    logic [FRAME_W-1:0]     r_mem_frame [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_valid;
    logic [PAGE_W-1:0]      r_rd_page;
    logic [FRAME_W-1:0]     r_rd_frame;
    logic                   r_rd_valid;

    // Write page and frame; contents undefined until written
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_page[i_wr_addr]  <= i_wr.page;
            r_mem_frame[i_wr_addr] <= i_wr.frame;
        end
    end

    // Register the read word
    always_ff @(posedge i_clk) begin
        r_rd_page  <= r_mem_page[i_rd_addr];
        r_rd_frame <= r_mem_frame[i_rd_addr];
    end

    // Hold valid flags; clear all at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // Assemble the read word
    always_comb begin
        o_rd.valid = r_rd_valid;
        o_rd.page  = r_rd_page;
        o_rd.frame = r_rd_frame;
    end

endmodule

// File: rtl/core/tlb_fifo_translate_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_fifo_translate_core
// Fully associative TLB with FIFO replacement and sequential frame allocation.
// ----------------------------------------------------------------------------
// Usage:
//   i_addr carries one 16-bit logical address word (page in 15..8, offset in
//   7..0). o_res returns one translation word per address: hit flag, status,
//   page, frame, physical address and saturating hit and fault totals.
//   One address is in flight at a time; a new word is taken only once the
//   last one has passed the whole sequence. That sequence is set by the
//   single page comparator, which walks the entry store one entry per cycle
//   through its registered read port, followed by a tail state for the last
//   read word, an update state, the load of the output register in the done
//   state and a return to idle to take the next address.
//   The output register parts the two sides: the next address is accepted
//   while a finished result still waits. If the receiver stalls longer, the
//   core holds the following result in its done state and stops accepting.
//   Reset (synchronous, active low) clears all valid flags, the FIFO insert
//   pointer, the free-frame counter and both totals; no clearing pass runs.
//   Once FRAME_COUNT frames are assigned, a miss reports status 1 with frame
//   and address zero, inserts nothing and still counts as a fault.
// ----------------------------------------------------------------------------
module tlb_fifo_translate_core
    import tft_pkg::*;
#(
    parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
    parameter int FRAME_COUNT = DEF_FRAME_COUNT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tft_in_if.sink     i_addr,
    tft_out_if.source  o_res
);

    localparam int IW     = $clog2(TLB_ENTRIES);
    localparam int FREE_W = $clog2(FRAME_COUNT + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_UPDATE,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [PAGE_W-1:0]   r_page;
    logic [OFFSET_W-1:0] r_offset;
    logic [IW-1:0]       r_scan_addr;
    logic                r_cmp_en;
    logic                r_found;
    logic [FRAME_W-1:0]  r_found_frame;
    logic [IW-1:0]       r_ins_ptr;
    logic [FREE_W-1:0]   r_next_free;
    logic [CNT_W-1:0]    r_hit_cnt;
    logic [CNT_W-1:0]    r_fault_cnt;
    logic                r_res_hit;
    logic                r_res_status;
    logic [FRAME_W-1:0]  r_res_frame;

    logic                r_o_valid;
    logic                r_o_hit;
    logic                r_o_status;
    logic [PAGE_W-1:0]   r_o_page;
    logic [FRAME_W-1:0]  r_o_frame;
    logic [PHYS_W-1:0]   r_o_phys;
    logic [CNT_W-1:0]    r_o_hit_total;
    logic [CNT_W-1:0]    r_o_fault_total;

    logic                in_take;
    logic                out_free;
    logic                scan_last;
    logic                cmp_match;
    logic                frames_left;
    t_wr_req             wr_req;
    t_rd_data            rd_data;

    // Wrap the FIFO insert pointer at the last entry
    function automatic logic [IW-1:0] scan_last_ptr(input logic [IW-1:0] ptr);
        logic [IW-1:0] nxt;
        nxt = (ptr == IW'(TLB_ENTRIES - 1)) ? '0 : ptr + IW'(1);
        return nxt;
    endfunction

    // Entry store with its single read port
    tft_tlb_store #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_scan_addr),
        .i_wr_addr (r_ins_ptr),
        .i_wr      (wr_req),
        .o_rd      (rd_data)
    );

    // Handshake and shared comparator
    assign in_take     = i_addr.valid && (r_state == S_IDLE);
    assign out_free    = !r_o_valid || o_res.ready;
    assign scan_last   = (r_scan_addr == IW'(TLB_ENTRIES - 1));
    assign cmp_match   = r_cmp_en && rd_data.valid && (rd_data.page == r_page);
    assign frames_left = (r_next_free < FREE_W'(FRAME_COUNT));

    // Insert on a miss while frames remain
    always_comb begin
        wr_req.en    = (r_state == S_UPDATE) && !r_found && frames_left;
        wr_req.page  = r_page;
        wr_req.frame = FRAME_W'(r_next_free);
    end

    // Sequence: accept, walk entries, update, hand over
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_take) n_state = S_SCAN;
            S_SCAN:   if (scan_last) n_state = S_TAIL;
            S_TAIL:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // State, scan and bookkeeping registers, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_en    <= 1'b0;
            r_found     <= 1'b0;
            r_scan_addr <= '0;
            r_ins_ptr   <= '0;
            r_next_free <= '0;
            r_hit_cnt   <= '0;
            r_fault_cnt <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cmp_en <= (r_state == S_SCAN);

            // Latch the address word and restart the walk
            if (in_take) begin
                r_page      <= i_addr.logical_address[ADDR_W-1 -: PAGE_W];
                r_offset    <= i_addr.logical_address[OFFSET_W-1:0];
                r_scan_addr <= '0;
                r_found     <= 1'b0;
            end else if (r_state == S_SCAN && !scan_last) begin
                r_scan_addr <= r_scan_addr + IW'(1);
            end

            // Keep the lowest matching entry
            if (cmp_match && !r_found) begin
                r_found       <= 1'b1;
                r_found_frame <= rd_data.frame;
            end

            // Count, allocate and advance the FIFO pointer
            if (r_state == S_UPDATE) begin
                r_res_hit <= r_found;
                if (r_found) begin
                    r_res_status <= 1'b0;
                    r_res_frame  <= r_found_frame;
                    if (r_hit_cnt != CNT_MAX) r_hit_cnt <= r_hit_cnt + CNT_W'(1);
                end else begin
                    if (r_fault_cnt != CNT_MAX) begin
                        r_fault_cnt <= r_fault_cnt + CNT_W'(1);
                    end
                    if (frames_left) begin
                        r_res_status <= 1'b0;
                        r_res_frame  <= FRAME_W'(r_next_free);
                        r_next_free  <= r_next_free + FREE_W'(1);
                        r_ins_ptr    <= scan_last_ptr(r_ins_ptr);
                    end else begin
                        r_res_status <= 1'b1;
                        r_res_frame  <= '0;
                    end
                end
            end

            // Load the output word, or drop it once taken
            if (r_state == S_DONE && out_free) begin
                r_o_valid       <= 1'b1;
                r_o_hit         <= r_res_hit;
                r_o_status      <= r_res_status;
                r_o_page        <= r_page;
                r_o_frame       <= r_res_frame;
                r_o_phys        <= r_res_status ? '0 : {r_res_frame, r_offset};
                r_o_hit_total   <= r_hit_cnt;
                r_o_fault_total <= r_fault_cnt;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Drive the channels
    assign i_addr.ready           = (r_state == S_IDLE);
    assign o_res.valid            = r_o_valid;
    assign o_res.tlb_hit          = r_o_hit;
    assign o_res.status           = r_o_status;
    assign o_res.page_number      = r_o_page;
    assign o_res.frame_number     = r_o_frame;
    assign o_res.physical_address = r_o_phys;
    assign o_res.hit_total        = r_o_hit_total;
    assign o_res.fault_total      = r_o_fault_total;

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_addr.valid && i_addr.ready) |=> !i_addr.ready)
        else $error("address accepted while a walk is in progress");

    a_insert_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_req.en |-> (!r_found && r_next_free < FREE_W'(FRAME_COUNT)))
        else $error("entry written on a hit or with no frame left");

    a_exhausted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status) |->
            (!o_res.tlb_hit && o_res.frame_number == '0 && o_res.physical_address == '0))
        else $error("exhaustion result carries a frame or a hit");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= FREE_W'(FRAME_COUNT))
        else $error("free-frame counter ran past the frame count");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FIFO-replacement TLB translation core.
// Address words go in over one valid/ready channel and translation words come
// back over another. A scoreboard class keeps its own copy of the TLB, the
// frame allocator and the totals. It predicts every translation word in
// order and compares each returned word with the oldest prediction, field by
// field. A short directed run covers the field extremes, hits, FIFO
// wrap-around and eviction. Random traffic then mostly re-uses resident
// pages, runs the frame pool dry and carries on past exhaustion. Both sides
// idle at random, with one long receiver hold and one drain pause.
// ----------------------------------------------------------------------------
module tb
    import tft_pkg::*;
;

    localparam int TLB_ENTRIES    = DEF_TLB_ENTRIES;
    localparam int FRAME_COUNT    = DEF_FRAME_COUNT;
    localparam int RANDOM_WORDS   = 1080;
    localparam int DRAIN_PAUSE_AT = 700;
    localparam int BURST_FIRST    = 150;
    localparam int BURST_LAST     = 260;
    localparam int HOLD_AFTER     = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    // Status codes of a translation word
    localparam logic ST_TRANSLATED = 1'b0;
    localparam logic ST_NO_FRAME   = 1'b1;

    typedef struct {
        logic               hit;
        logic               status;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic [PHYS_W-1:0]  phys;
        logic [CNT_W-1:0]   hits;
        logic [CNT_W-1:0]   faults;
    } t_xlat;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow TLB, frame allocator and the queue of owed words
    // ------------------------------------------------------------------------
    class xlat_scoreboard;
        logic [PAGE_W-1:0]  slot_page  [TLB_ENTRIES];
        logic [FRAME_W-1:0] slot_frame [TLB_ENTRIES];
        bit                 slot_live  [TLB_ENTRIES];
        int unsigned        fifo_slot;
        int unsigned        frames_given;
        logic [CNT_W-1:0]   hit_cnt;
        logic [CNT_W-1:0]   fault_cnt;
        logic [PAGE_W-1:0]  page_log [$];
        t_xlat              owed_xlat [$];
        int                 errors;
        int                 checked;
        int                 n_hits;
        int                 n_no_frame;
        int                 n_wraps;

        function new();
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            fifo_slot    = 0;
            frames_given = 0;
            hit_cnt      = '0;
            fault_cnt    = '0;
            errors       = 0;
            checked      = 0;
            n_hits       = 0;
            n_no_frame   = 0;
            n_wraps      = 0;
        endfunction

        // Predict the translation of one accepted address word
        function void note_address(logic [ADDR_W-1:0] addr);
            t_xlat               r;
            int                  idx;
            logic [PAGE_W-1:0]   pg;
            logic [OFFSET_W-1:0] off;
            pg  = addr[ADDR_W-1:OFFSET_W];
            off = addr[OFFSET_W-1:0];
            idx = -1;
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                if (idx < 0 && slot_live[i] && slot_page[i] == pg) idx = i;
            end
            r.hit    = (idx >= 0);
            r.status = ST_TRANSLATED;
            r.page   = pg;
            r.frame  = '0;
            if (idx >= 0) begin
                r.frame = slot_frame[idx];
                if (hit_cnt != CNT_MAX) hit_cnt = hit_cnt + 1'b1;
                n_hits++;
            end else begin
                if (fault_cnt != CNT_MAX) fault_cnt = fault_cnt + 1'b1;
                if (frames_given < FRAME_COUNT) begin
                    // Take the next frame and overwrite the oldest slot
                    r.frame               = FRAME_W'(frames_given);
                    slot_page[fifo_slot]  = pg;
                    slot_frame[fifo_slot] = r.frame;
                    slot_live[fifo_slot]  = 1'b1;
                    page_log.push_back(pg);
                    if (fifo_slot == TLB_ENTRIES - 1) n_wraps++;
                    fifo_slot    = (fifo_slot + 1) % TLB_ENTRIES;
                    frames_given = frames_given + 1;
                end else begin
                    r.status = ST_NO_FRAME;
                    n_no_frame++;
                end
            end
            r.phys   = (r.status == ST_NO_FRAME) ? '0 : {r.frame, off};
            r.hits   = hit_cnt;
            r.faults = fault_cnt;
            owed_xlat.push_back(r);
        endfunction

        function void flag_field(string name, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t: word %0d %s mismatch: expected %0h, got %0h",
                         $realtime, checked, name, want, got);
        endfunction

        // Compare one returned word with the oldest prediction
        function void check_result(t_xlat got);
            t_xlat want;
            if (owed_xlat.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: translation word with none owed (page %0h)",
                             $realtime, got.page);
                return;
            end
            want = owed_xlat.pop_front();
            if (got.hit !== want.hit)
                flag_field("tlb_hit", 32'(want.hit), 32'(got.hit));
            if (got.status !== want.status)
                flag_field("status", 32'(want.status), 32'(got.status));
            if (got.page !== want.page)
                flag_field("page_number", 32'(want.page), 32'(got.page));
            if (got.frame !== want.frame)
                flag_field("frame_number", 32'(want.frame), 32'(got.frame));
            if (got.phys !== want.phys)
                flag_field("physical_address", 32'(want.phys), 32'(got.phys));
            if (got.hits !== want.hits)
                flag_field("hit_total", 32'(want.hits), 32'(got.hits));
            if (got.faults !== want.faults)
                flag_field("fault_total", 32'(want.faults), 32'(got.faults));
            checked++;
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tft_in_if  addr_if ();
    tft_out_if res_if ();

    xlat_scoreboard sb = new();
    bit             no_idle = 1'b0;
    bit             hold_done = 1'b0;
    int             idle_cycles = 0;

    tlb_fifo_translate_core #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .FRAME_COUNT (FRAME_COUNT)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (addr_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one, none inside the burst window
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    // Favour resident pages so that hits stay common; mix in evicted, fresh
    // and wholly random words
    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned         roll;
        int unsigned         slot;
        logic [PAGE_W-1:0]   pg;
        logic [OFFSET_W-1:0] off;
        roll = $urandom_range(0, 99);
        off  = OFFSET_W'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) off = $urandom_range(0, 1) ? '1 : '0;
        if (roll < 55) begin
            slot = $urandom_range(0, TLB_ENTRIES - 1);
            while (!sb.slot_live[slot]) slot = $urandom_range(0, TLB_ENTRIES - 1);
            pg = sb.slot_page[slot];
        end else if (roll < 70 && sb.page_log.size() > 0) begin
            pg = sb.page_log[$urandom_range(0, sb.page_log.size() - 1)];
        end else if (roll < 90) begin
            pg = PAGE_W'($urandom_range(0, 255));
        end else begin
            return ADDR_W'($urandom_range(0, 65535));
        end
        return {pg, off};
    endfunction

    // Offer one address word and hold it until taken; valid stays high
    // afterwards so back-to-back words need no second assignment
    task automatic send_word(input logic [ADDR_W-1:0] addr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            addr_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        addr_if.valid           <= 1'b1;
        addr_if.logical_address <= addr;
        do @(posedge i_clk); while (!addr_if.ready);
        sb.note_address(addr);
    endtask

    // Hold the input off until every owed word has returned
    task automatic drain_pause();
        addr_if.valid <= 1'b0;
        while (sb.owed_xlat.size() != 0) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin : address_feed
        logic [ADDR_W-1:0] directed [$];
        addr_if.valid           <= 1'b0;
        addr_if.logical_address <= '0;
        // Extremes, hits on fresh entries, then enough new pages to wrap the
        // FIFO, evict page zero and miss on it again
        directed = '{16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00, 16'hAA55, 16'h55AA};
        for (int p = 8'h10; p <= 8'h1C; p++) directed.push_back({p[7:0], 8'h3C});
        directed.push_back(16'h0012);
        directed.push_back(16'hFF80);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_word(directed[i]);
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == DRAIN_PAUSE_AT) drain_pause();
            no_idle = (n >= BURST_FIRST && n <= BURST_LAST);
            send_word(pick_address());
        end
        no_idle = 1'b0;
        addr_if.valid <= 1'b0;

        while (sb.owed_xlat.size() != 0) @(posedge i_clk);
        repeat (2 * TLB_ENTRIES + 8) @(posedge i_clk);

        $display("Checked %0d translations: %0d TLB hits, %0d misses without a frame,",
                 sb.checked, sb.n_hits, sb.n_no_frame);
        $display("%0d FIFO wraps, %0d frames handed out, with stalls on both sides.",
                 sb.n_wraps, sb.frames_given);
        if (sb.errors == 0 && sb.owed_xlat.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Receiver: random ready pattern plus one long hold to back the core up
    initial begin : result_drain
        int n;
        res_if.ready <= 1'b0;
        forever begin
            if (!hold_done && sb.checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                n = HOLD_CYCLES;
            end else begin
                n = pick_gap();
            end
            if (n > 0) begin
                res_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // Check every translation word taken by the receiver
    always @(posedge i_clk) begin
        t_xlat got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.hit    = res_if.tlb_hit;
            got.status = res_if.status;
            got.page   = res_if.page_number;
            got.frame  = res_if.frame_number;
            got.phys   = res_if.physical_address;
            got.hits   = res_if.hit_total;
            got.faults = res_if.fault_total;
            sb.check_result(got);
        end
    end

    // Watchdog: give up after a long stretch with no word moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (addr_if.valid && addr_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timed out with %0d translations still owed.", sb.owed_xlat.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
